FILE: src/sws_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sws_pkg
// Shared types and codes of the shell word splitter.
// -----------------------------------------------------------------------------
package sws_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    // result kinds
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_WORD_END  = 2'd1;
    localparam logic [1:0] KIND_INPUT_END = 2'd2;
    localparam logic [1:0] KIND_ERROR     = 2'd3;

    // quote modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;

    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

    // All results caused by one input item, in emission order:
    // sep_end, chr, err, word_end, input_end.
    typedef struct packed {
        logic       sep_end;
        logic       chr;
        logic [7:0] ch;
        logic       err;
        logic       word_end;
        logic       input_end;
    } run_t;

    // queue status between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } qctl_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

FILE: src/sws_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sws_in_if / sws_out_if
// Valid/ready channels for input bytes and result items.
// -----------------------------------------------------------------------------
interface sws_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface sws_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output kind, output out_char, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input out_char, input last_of_run,
                    output ready);
endinterface

FILE: src/sws_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sws_front
// Accept bytes, track quoting state, and build the result run of each item.
// -----------------------------------------------------------------------------
module sws_front (
    input  logic          clk,
    input  logic          rst_n,
    sws_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          q_push,
    output sws_pkg::run_t q_data
);
    import sws_pkg::*;

    logic [1:0] mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic       sep_reg, sep_next;
    logic       ws_reg, ws_next;
    run_t       run;
    logic       accept;
    logic [7:0] c;

    assign c         = in_ch.char_code;
    assign in_ch.ready = !q_full;
    assign accept    = in_ch.valid && !q_full;

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        sep_next  = sep_reg;
        ws_next   = ws_reg;
        run       = '0;
        if (esc_reg)
        begin
            esc_next = 1'b0;
            run.chr  = 1'b1;
            run.ch   = c;
        end
        else if (mode_reg == MODE_SINGLE)
        begin
            if (c == CHAR_SQUOTE)
                mode_next = MODE_NONE;
            else
            begin
                run.chr = 1'b1;
                run.ch  = c;
            end
        end
        else if (mode_reg == MODE_DOUBLE)
        begin
            if (c == CHAR_DQUOTE)
                mode_next = MODE_NONE;
            else if (c == CHAR_BACKSLASH)
                esc_next = 1'b1;
            else
            begin
                run.chr = 1'b1;
                run.ch  = c;
            end
        end
        else
        begin
            mode_next = MODE_NONE;
            if (is_space(c))
            begin
                if (ws_reg)
                    sep_next = 1'b1;
            end
            else
            begin
                if (sep_reg)
                begin
                    sep_next    = 1'b0;
                    run.sep_end = 1'b1;
                end
                ws_next = 1'b1;
                if (c == CHAR_SQUOTE)
                    mode_next = MODE_SINGLE;
                else if (c == CHAR_DQUOTE)
                    mode_next = MODE_DOUBLE;
                else if (c == CHAR_BACKSLASH)
                    esc_next = 1'b1;
                else
                begin
                    run.chr = 1'b1;
                    run.ch  = c;
                end
            end
        end

        if (in_ch.end_of_input)
        begin
            if ((mode_next == MODE_SINGLE) || (mode_next == MODE_DOUBLE))
                run.err = 1'b1;
            else
            begin
                run.word_end  = ws_next;
                run.input_end = 1'b1;
            end
            mode_next = MODE_NONE;
            esc_next  = 1'b0;
            sep_next  = 1'b0;
            ws_next   = 1'b0;
        end
    end

    // drop items that cause no result
    assign q_push = accept && (run.sep_end || run.chr || run.err ||
                               run.word_end || run.input_end);
    assign q_data = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NONE;
            esc_reg  <= 1'b0;
            sep_reg  <= 1'b0;
            ws_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            sep_reg  <= sep_next;
            ws_reg   <= ws_next;
        end
    end

endmodule

FILE: src/sws_queue.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sws_queue
// Short FIFO of result runs between front and back.
// -----------------------------------------------------------------------------
module sws_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  sws_pkg::run_t wr_data,
    output sws_pkg::run_t rd_data,
    input  logic          push,
    input  logic          pop,
    output sws_pkg::qctl_t stat
);
    import sws_pkg::*;

    run_t                 mem_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QueueCntW-1:0] cnt_reg;
    logic                 full, empty, do_push, do_pop;

    assign full    = (cnt_reg == QueueCntW'(QueueDepth));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    assign stat.full  = full;
    assign stat.empty = empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QueuePtrW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QueuePtrW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + QueueCntW'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - QueueCntW'(1);
        end
    end

endmodule

FILE: src/sws_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sws_back
// Unroll each queued run into result items, one per cycle while out_ch is ready.
// -----------------------------------------------------------------------------
module sws_back (
    input  logic          clk,
    input  logic          rst_n,
    input  sws_pkg::run_t q_data,
    input  logic          q_empty,
    output logic          q_pop,
    sws_out_if.source     out_ch
);
    import sws_pkg::*;

    run_t cur_reg, cur_next;
    run_t rest;
    logic busy, fire, load;
    logic [1:0] kind;

    assign busy = cur_reg.sep_end || cur_reg.chr || cur_reg.err ||
                  cur_reg.word_end || cur_reg.input_end;

    // pick the first pending result, clear it in rest
    always_comb
    begin
        rest = cur_reg;
        kind = KIND_CHAR;
        if (cur_reg.sep_end)
        begin
            kind         = KIND_WORD_END;
            rest.sep_end = 1'b0;
        end
        else if (cur_reg.chr)
        begin
            kind     = KIND_CHAR;
            rest.chr = 1'b0;
        end
        else if (cur_reg.err)
        begin
            kind     = KIND_ERROR;
            rest.err = 1'b0;
        end
        else if (cur_reg.word_end)
        begin
            kind          = KIND_WORD_END;
            rest.word_end = 1'b0;
        end
        else
        begin
            kind           = KIND_INPUT_END;
            rest.input_end = 1'b0;
        end
    end

    logic rest_busy;
    assign rest_busy = rest.sep_end || rest.chr || rest.err ||
                       rest.word_end || rest.input_end;

    assign fire  = busy && out_ch.ready;
    assign load  = !q_empty && (!busy || (fire && !rest_busy));
    assign q_pop = load;

    always_comb
    begin
        cur_next = cur_reg;
        if (load)
            cur_next = q_data;
        else if (fire)
            cur_next = rest;
    end

    assign out_ch.valid       = busy;
    assign out_ch.kind        = kind;
    assign out_ch.out_char    = (kind == KIND_CHAR) ? cur_reg.ch : 8'd0;
    assign out_ch.last_of_run = !rest_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else
            cur_reg <= cur_next;
    end

endmodule

FILE: src/shell_word_splitter_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// shell_word_splitter_unit
// Streaming shell-style word splitter, one command line byte per item.
// -----------------------------------------------------------------------------
// The block takes one byte per cycle on in_ch while the queue has room and
// streams result items on out_ch: kept bytes (kind 0), word ends (1), the
// input end (2) or an unbalanced quote error (3); last_of_run marks the final
// result of a byte. The front stage updates the quoting state in the accepting
// cycle and packs all results of the byte into one run; a four-entry queue
// holds runs; the back stage emits one result item per cycle while out_ch is
// ready. A byte causes 0 to 4 results, and input stalls only when the queue is
// full, from result-heavy bytes or a slow receiver. The first result of a byte
// passes through its queue entry and then the back stage's current-run
// register. End of line returns all state to reset for the next line.
// -----------------------------------------------------------------------------
module shell_word_splitter_unit (
    input  logic      clk,
    input  logic      rst_n,
    sws_in_if.sink    in_ch,
    sws_out_if.source out_ch
);
    import sws_pkg::*;

    run_t  push_data;
    run_t  head_data;
    logic  push;
    logic  pop;
    qctl_t qstat;

    // classify bytes and hold quoting state
    sws_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (qstat.full),
        .q_push (push),
        .q_data (push_data)
    );

    // decouple front and back
    sws_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (push_data),
        .rd_data (head_data),
        .push    (push),
        .pop     (pop),
        .stat    (qstat)
    );

    // emit result items
    sws_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (head_data),
        .q_empty (qstat.empty),
        .q_pop   (pop),
        .out_ch  (out_ch)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming shell word splitter.
// -----------------------------------------------------------------------------
// Command line bytes are fed over the input channel one item at a time. A
// behavioral word splitter inside the bench tracks quoting, escapes and word
// boundaries and queues the result items that each accepted byte must cause.
// Every result item taken from the output channel is checked field by field
// against the oldest queued one. Stimulus runs as directed lines covering
// trimming, quoting, escapes and line end cases, then randomly built lines
// (well-formed, broken and pure noise), then a back-pressure burst. Both
// channel sides insert random idle cycles.
// -----------------------------------------------------------------------------
module tb_top;

    import sws_pkg::*;

    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_BYTES = 100;
    localparam int unsigned MAX_IDLE     = 12;
    localparam int unsigned TAIL_CYCLES  = 10;

    // whitespace bytes recognized by the splitter, then other test bytes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MAX   = 8'hFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_char;
        logic       last_of_run;
    } splitter_result_t;

    typedef logic [7:0] byte_queue_t[$];

    logic clk;
    logic rst_n;

    sws_in_if  in_ch();
    sws_out_if out_ch();

    shell_word_splitter_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // word splitter state as the bench sees it
    logic [1:0] quote_state;
    logic       escape_armed;
    logic       gap_seen;
    logic       word_open;

    splitter_result_t pending_results[$];
    splitter_result_t oldest_result;
    byte_queue_t      line_buf;

    int unsigned fail_count;
    int unsigned bytes_fed;
    int unsigned cycle_count;
    int unsigned rx_stall;
    int unsigned hold_cycles;
    bit          tx_idle_on;
    bit          rx_idle_on;

    // -------------------------------------------------------------------------
    // Clock and cycle limit
    // -------------------------------------------------------------------------
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // A hang anywhere ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles, %0d results still queued",
                     $time, CYCLE_LIMIT, pending_results.size());
            $display("shell_word_splitter_unit verification failed");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // Prediction
    // -------------------------------------------------------------------------
    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic void clear_split_state();
        quote_state  = MODE_NONE;
        escape_armed = 1'b0;
        gap_seen     = 1'b0;
        word_open    = 1'b0;
    endfunction

    // Advance the splitter by one byte and queue the result items it causes.
    function automatic void split_byte(input logic [7:0] c, input logic eol);
        splitter_result_t run[4];
        int               n;
        n = 0;
        if (escape_armed)
        begin
            // an escaped byte is always kept, whitespace included
            escape_armed = 1'b0;
            run[n++] = '{KIND_CHAR, c, 1'b0};
        end
        else if (quote_state == MODE_SINGLE)
        begin
            if (c == CHAR_SQUOTE)
                quote_state = MODE_NONE;
            else
                run[n++] = '{KIND_CHAR, c, 1'b0};
        end
        else if (quote_state == MODE_DOUBLE)
        begin
            if (c == CHAR_DQUOTE)
                quote_state = MODE_NONE;
            else if (c == CHAR_BACKSLASH)
                escape_armed = 1'b1;
            else
                run[n++] = '{KIND_CHAR, c, 1'b0};
        end
        else
        begin
            quote_state = MODE_NONE;
            if (is_blank(c))
            begin
                // leading blanks are dropped, later ones mark a separator
                if (word_open)
                    gap_seen = 1'b1;
            end
            else
            begin
                if (gap_seen)
                begin
                    gap_seen = 1'b0;
                    run[n++] = '{KIND_WORD_END, 8'h00, 1'b0};
                end
                word_open = 1'b1;
                if (c == CHAR_SQUOTE)
                    quote_state = MODE_SINGLE;
                else if (c == CHAR_DQUOTE)
                    quote_state = MODE_DOUBLE;
                else if (c == CHAR_BACKSLASH)
                    escape_armed = 1'b1;
                else
                    run[n++] = '{KIND_CHAR, c, 1'b0};
            end
        end

        if (eol)
        begin
            // open quote: error only; else close the word and end the line
            if (quote_state == MODE_SINGLE || quote_state == MODE_DOUBLE)
                run[n++] = '{KIND_ERROR, 8'h00, 1'b0};
            else
            begin
                if (word_open)
                    run[n++] = '{KIND_WORD_END, 8'h00, 1'b0};
                run[n++] = '{KIND_INPUT_END, 8'h00, 1'b0};
            end
            clear_split_state();
        end

        if (n > 0)
            run[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            pending_results.insert(pending_results.size(), run[i]);
    endfunction

    // -------------------------------------------------------------------------
    // Result receiver: drive ready at the falling edge
    // -------------------------------------------------------------------------
    // A long hold-off takes priority over the per-item stall.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (rx_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                rx_stall--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // -------------------------------------------------------------------------
    // Result checker: sample at the rising edge
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got kind %0d char %02h last %0d",
                         $time, out_ch.kind, out_ch.out_char, out_ch.last_of_run);
                fail_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (out_ch.kind !== oldest_result.kind)
                begin
                    $display("%0t: kind mismatch, expected %0d, got %0d",
                             $time, oldest_result.kind, out_ch.kind);
                    fail_count++;
                end
                if (out_ch.out_char !== oldest_result.out_char)
                begin
                    $display("%0t: out_char mismatch, expected %02h, got %02h",
                             $time, oldest_result.out_char, out_ch.out_char);
                    fail_count++;
                end
                if (out_ch.last_of_run !== oldest_result.last_of_run)
                begin
                    $display("%0t: last_of_run mismatch, expected %0d, got %0d",
                             $time, oldest_result.last_of_run, out_ch.last_of_run);
                    fail_count++;
                end
            end
            // draw the stall before the next result
            rx_stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        end
    end

    // -------------------------------------------------------------------------
    // Byte sender
    // -------------------------------------------------------------------------
    // Hold valid high across back-to-back items; drop it only for a gap.
    task automatic send_byte(input logic [7:0] c, input logic eol);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.char_code    <= c;
        in_ch.end_of_input <= eol;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        split_byte(c, eol);
        bytes_fed++;
    endtask

    // Send a whole line; the last byte carries end of input.
    task automatic send_line(input byte_queue_t bytes);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Stop offering items until every queued result has come out.
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // -------------------------------------------------------------------------
    // Random line building
    // -------------------------------------------------------------------------
    // append one byte to the line under construction
    function automatic void append_byte(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // any byte that is neither whitespace, a quote nor a backslash
    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_blank(c) || c == CHAR_SQUOTE || c == CHAR_DQUOTE ||
               c == CHAR_BACKSLASH);
        return c;
    endfunction

    // one word built from plain runs, escapes and quoted segments
    function automatic void add_word();
        logic [7:0] c;
        int unsigned parts;
        parts = $urandom_range(1, 3);
        for (int p = 0; p < parts; p++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    repeat ($urandom_range(1, 3)) append_byte(pick_plain());
                5, 6:
                begin
                    append_byte(CHAR_BACKSLASH);
                    append_byte(8'($urandom_range(0, 255)));
                end
                7, 8:
                begin
                    append_byte(CHAR_SQUOTE);
                    repeat ($urandom_range(0, 3))
                    begin
                        do
                            c = 8'($urandom_range(0, 255));
                        while (c == CHAR_SQUOTE);
                        append_byte(c);
                    end
                    append_byte(CHAR_SQUOTE);
                end
                default:
                begin
                    append_byte(CHAR_DQUOTE);
                    repeat ($urandom_range(0, 3))
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            append_byte(CHAR_BACKSLASH);
                            append_byte(8'($urandom_range(0, 255)));
                        end
                        else
                        begin
                            do
                                c = 8'($urandom_range(0, 255));
                            while (c == CHAR_DQUOTE || c == CHAR_BACKSLASH);
                            append_byte(c);
                        end
                    end
                    append_byte(CHAR_DQUOTE);
                end
            endcase
        end
    endfunction

    // leading blanks, words split by blank runs, trailing blanks
    function automatic void build_good_line();
        int unsigned words;
        line_buf.delete();
        repeat ($urandom_range(0, 2)) append_byte(pick_blank());
        words = $urandom_range(0, 3);
        for (int w = 0; w < words; w++)
        begin
            if (w > 0)
                repeat ($urandom_range(1, 2)) append_byte(pick_blank());
            add_word();
        end
        // a dangling backslash now and then
        if ($urandom_range(0, 7) == 0)
            append_byte(CHAR_BACKSLASH);
        repeat ($urandom_range(0, 2)) append_byte(pick_blank());
        if (line_buf.size() == 0)
            append_byte(pick_blank());
    endfunction

    // -------------------------------------------------------------------------
    // Tests
    // -------------------------------------------------------------------------
    // Trimming, quoting, escapes, byte extremes and many ways a line can end.
    task automatic test_directed();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        // leading blanks, extreme bytes around a blank, trailing newline
        send_line('{CH_SPACE, CH_TAB, CH_NUL, CH_CR, CH_MAX, CH_LF});
        // single quoted blank, then a double quoted escaped quote
        send_line('{CHAR_SQUOTE, CH_SPACE, CHAR_SQUOTE, CHAR_DQUOTE,
                    CHAR_BACKSLASH, CHAR_DQUOTE, CHAR_DQUOTE});
        // escaped whitespace on the last byte
        send_line('{CHAR_BACKSLASH, CH_TAB});
        // a lone backslash still makes an empty word
        send_line('{CHAR_BACKSLASH});
        // open double quote at line end
        send_line('{CHAR_DQUOTE});
        // backslash is literal in single quotes, quote left open
        send_line('{CHAR_SQUOTE, CHAR_BACKSLASH});
        // whitespace only line
        send_line('{CH_FF, CH_VT});
        // empty quoted word
        send_line('{CHAR_SQUOTE, CHAR_SQUOTE});
        wait_drained();
    endtask

    // Mostly well-formed lines with random content, some broken, some noise.
    task automatic test_random_lines();
        int unsigned target;
        int unsigned pick;
        target = bytes_fed + RANDOM_BYTES;
        while (bytes_fed < target)
        begin
            // stretches without idling on either side
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 19);
            if (pick < 14)
                build_good_line();
            else if (pick < 17)
            begin
                // leave a quote open at the end
                build_good_line();
                append_byte($urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE);
                repeat ($urandom_range(0, 2)) append_byte(pick_plain());
            end
            else
            begin
                line_buf.delete();
                repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
            end
            send_line(line_buf);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Hold the receiver off while result-heavy bytes arrive back to back.
    task automatic test_backpressure();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        hold_cycles = 80;
        // each "a b" line ends in four results on its last byte
        repeat (8)
            send_line('{CH_A, CH_SPACE, CH_B});
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // -------------------------------------------------------------------------
    // Sequence
    // -------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.char_code    = 8'h00;
        in_ch.end_of_input = 1'b0;
        fail_count         = 0;
        bytes_fed          = 0;
        cycle_count        = 0;
        rx_stall           = 0;
        hold_cycles        = 0;
        tx_idle_on         = 1'b1;
        rx_idle_on         = 1'b1;
        clear_split_state();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_lines();
        test_backpressure();

        // catch anything emitted after the last expected result
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("shell_word_splitter_unit verification clean");
        else
            $display("shell_word_splitter_unit verification failed");
        $finish;
    end

endmodule

FILE: files.f
src/sws_pkg.sv
src/sws_if.sv
src/sws_front.sv
src/sws_queue.sv
src/sws_back.sv
src/shell_word_splitter_unit.sv
bench/tb_top.sv
